@@ rtl/btt_pkg.sv @@
// Shared types and constants for the bilinear travel-time table lookup.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package btt_pkg;

    localparam int MAX_ROWS_DEF   = 64;
    localparam int MAX_COLS_DEF   = 256;
    localparam int VALUE_BITS_DEF = 32;

    localparam logic [1:0] REG_GRID_STEP    = 2'd0;
    localparam logic [1:0] REG_DEPTH_ORIGIN = 2'd1;
    localparam logic [1:0] REG_NUM_COLS     = 2'd2;
    localparam logic [1:0] REG_NUM_ROWS     = 2'd3;

    localparam logic       REQ_WRITE  = 1'b0;
    localparam logic       REQ_LOOKUP = 1'b1;

    localparam logic [16:0] ONE_Q16 = 17'h10000;
    localparam int          DIV_BITS = 48;

    typedef struct packed {
        logic [31:0] grid_step;
        logic [31:0] depth_origin;
        logic [8:0]  num_cols;
        logic [6:0]  num_rows;
    } cfg_t;

    typedef struct packed {
        logic        lookup;
        logic        neg;
        logic [5:0]  row;
        logic [7:0]  col;
        logic [31:0] value;
        logic [31:0] distance;
        logic [31:0] ymag;
    } item_t;

endpackage
`default_nettype wire

@@ rtl/bilinear_traveltime_table_lookup.sv @@
// Lookup: a bit-serial divider run per axis, then serial multiply-accumulate
// over four corners; out-of-range ends on acceptance or after either divide.
// Writes go to the table as they are popped; a two-word queue sits in front.
// One item at a time in the back end, set by the shared bit-serial divider.
// Synchronous active-low reset clears control and loads register defaults;
// table contents are undefined until written.
`timescale 1ns / 1ps
`default_nettype none
module bilinear_traveltime_table_lookup #(
    parameter int MAX_ROWS   = btt_pkg::MAX_ROWS_DEF,
    parameter int MAX_COLS   = btt_pkg::MAX_COLS_DEF,
    parameter int VALUE_BITS = btt_pkg::VALUE_BITS_DEF
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               cfg_wr_en,
    input  wire logic [1:0]         cfg_addr,
    input  wire logic [31:0]        cfg_wdata,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire logic               s_req_type,
    input  wire logic [5:0]         s_row,
    input  wire logic [7:0]         s_col,
    input  wire logic [31:0]        s_entry_value,
    input  wire logic [31:0]        s_distance,
    input  wire logic signed [31:0] s_depth,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output logic [31:0]             m_travel_time,
    output logic                    m_out_of_range
);
    import btt_pkg::*;

    cfg_t  cfg_reg;
    logic  q_valid;
    item_t q_item;
    logic  q_pop;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.grid_step    <= 32'h0001_0000;
            cfg_reg.depth_origin <= 32'd0;
            cfg_reg.num_cols     <= 9'd256;
            cfg_reg.num_rows     <= 7'd64;
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                REG_GRID_STEP:    cfg_reg.grid_step    <= cfg_wdata;
                REG_DEPTH_ORIGIN: cfg_reg.depth_origin <= cfg_wdata;
                REG_NUM_COLS:     cfg_reg.num_cols     <= cfg_wdata[8:0];
                REG_NUM_ROWS:     cfg_reg.num_rows     <= cfg_wdata[6:0];
                default:          cfg_reg              <= cfg_reg;
            endcase
        end
    end

    btt_front u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg          (cfg_reg),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_req_type   (s_req_type),
        .s_row        (s_row),
        .s_col        (s_col),
        .s_entry_value(s_entry_value),
        .s_distance   (s_distance),
        .s_depth      (s_depth),
        .q_valid      (q_valid),
        .q_item       (q_item),
        .q_pop        (q_pop)
    );

    btt_back #(
        .MAX_ROWS  (MAX_ROWS),
        .MAX_COLS  (MAX_COLS),
        .VALUE_BITS(VALUE_BITS)
    ) u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg           (cfg_reg),
        .q_valid       (q_valid),
        .q_item        (q_item),
        .q_pop         (q_pop),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_travel_time (m_travel_time),
        .m_out_of_range(m_out_of_range)
    );
endmodule
`default_nettype wire

@@ rtl/btt_ram.sv @@
// Generic single-port RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
module btt_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] addr,
    input  wire logic [WIDTH-1:0]         wdata,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end
endmodule
`default_nettype wire

@@ rtl/btt_front.sv @@
// Front end: accepts words, classifies them and holds them in a two-entry queue.
// Depends on btt_pkg.
`timescale 1ns / 1ps
`default_nettype none
module btt_front (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire btt_pkg::cfg_t        cfg,
    input  wire logic                 s_valid,
    output logic                      s_ready,
    input  wire logic                 s_req_type,
    input  wire logic [5:0]           s_row,
    input  wire logic [7:0]           s_col,
    input  wire logic [31:0]          s_entry_value,
    input  wire logic [31:0]          s_distance,
    input  wire logic signed [31:0]   s_depth,
    output logic                      q_valid,
    output btt_pkg::item_t            q_item,
    input  wire logic                 q_pop
);
    import btt_pkg::*;

    item_t       slot_reg [2];
    logic        wptr_reg;
    logic        rptr_reg;
    logic [1:0]  count_reg;
    logic [1:0]  count_next;
    logic        push;
    logic        pop;
    logic [32:0] y;
    item_t       in_item;

    assign s_ready = (count_reg != 2'd2);
    assign push    = s_valid && s_ready;
    assign q_valid = (count_reg != 2'd0);
    assign pop     = q_pop && q_valid;
    assign q_item  = slot_reg[rptr_reg];

    always_comb begin
        y = {s_depth[31], s_depth} - {cfg.depth_origin[31], cfg.depth_origin};
        in_item.lookup   = (s_req_type == REQ_LOOKUP);
        in_item.neg      = y[32];
        in_item.row      = s_row;
        in_item.col      = s_col;
        in_item.value    = s_entry_value;
        in_item.distance = s_distance;
        in_item.ymag     = y[31:0];
        count_next = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wptr_reg] <= in_item;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wptr_reg  <= 1'b0;
            rptr_reg  <= 1'b0;
            count_reg <= 2'd0;
        end else begin
            if (push) begin
                wptr_reg <= ~wptr_reg;
            end
            if (pop) begin
                rptr_reg <= ~rptr_reg;
            end
            count_reg <= count_next;
        end
    end

    a_count_max: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg != 2'd3) else $error("queue count overflow");
    a_full_push: assert property (@(posedge aclk) disable iff (!aresetn)
        (count_reg == 2'd2 && !pop) |=> count_reg == 2'd2) else $error("full queue lost a word");
    a_ptr_gap: assert property (@(posedge aclk) disable iff (!aresetn)
        (count_reg == 2'd1) |-> (wptr_reg != rptr_reg)) else $error("queue pointers disagree");
endmodule
`default_nettype wire

@@ rtl/btt_back.sv @@
// Back end: table writes, shared restoring divider and serial bilinear blend.
// Depends on btt_pkg and btt_ram.
`timescale 1ns / 1ps
`default_nettype none
module btt_back #(
    parameter int MAX_ROWS   = btt_pkg::MAX_ROWS_DEF,
    parameter int MAX_COLS   = btt_pkg::MAX_COLS_DEF,
    parameter int VALUE_BITS = btt_pkg::VALUE_BITS_DEF
) (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire btt_pkg::cfg_t   cfg,
    input  wire logic            q_valid,
    input  wire btt_pkg::item_t  q_item,
    output logic                 q_pop,
    output logic                 m_valid,
    input  wire logic            m_ready,
    output logic [31:0]          m_travel_time,
    output logic                 m_out_of_range
);
    import btt_pkg::*;

    localparam int RW  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int CW  = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam int AW  = RW + CW;
    localparam int VB  = VALUE_BITS;
    localparam int PW  = VB + 17;
    localparam int SW  = VB + 18;
    localparam int CNTW = $clog2(DIV_BITS);

    typedef enum logic [7:0] {
        S_IDLE = 8'b0000_0001,
        S_DIVX = 8'b0000_0010,
        S_DIVY = 8'b0000_0100,
        S_RD   = 8'b0000_1000,
        S_MUL  = 8'b0001_0000,
        S_ADD  = 8'b0010_0000,
        S_OUT  = 8'b0100_0000
    } state_t;

    state_t               state_reg;
    logic [DIV_BITS-1:0]  dvd_reg;
    logic [32:0]          rem_reg;
    logic [CNTW-1:0]      cnt_reg;
    logic [31:0]          ymag_reg;
    logic [CW-1:0]        cx_reg;
    logic [RW-1:0]        ry_reg;
    logic [15:0]          wx_reg;
    logic [15:0]          wy_reg;
    logic [2:0]           k_reg;
    logic [PW-1:0]        prod_reg;
    logic [SW-1:0]        acc_reg;
    logic [VB-1:0]        top_reg;
    logic [VB-1:0]        bot_reg;
    logic [31:0]          res_reg;
    logic                 oor_reg;
    logic                 m_valid_reg;
    logic [31:0]          tt_reg;
    logic                 m_oor_reg;

    logic [32:0]          rem_shift;
    logic                 qbit;
    logic [32:0]          rem_new;
    logic [DIV_BITS-1:0]  quo;
    logic [31:0]          cols_eff;
    logic [31:0]          rows_eff;
    logic                 early_oor;
    logic                 wr_ok;
    logic                 ram_we;
    logic [AW-1:0]        ram_addr;
    logic [VB-1:0]        ram_wdata;
    logic [VB-1:0]        ram_rdata;
    logic [CW-1:0]        rd_col;
    logic [RW-1:0]        rd_row;
    logic [VB-1:0]        opnd;
    logic [16:0]          wgt;
    logic [15:0]          wsel;
    logic [SW-1:0]        sum;
    logic [VB-1:0]        half;
    logic                 out_free;

    assign out_free = !m_valid_reg || m_ready;

    always_comb begin
        cols_eff  = (32'(cfg.num_cols) > 32'(MAX_COLS)) ? 32'(MAX_COLS) : 32'(cfg.num_cols);
        rows_eff  = (32'(cfg.num_rows) > 32'(MAX_ROWS)) ? 32'(MAX_ROWS) : 32'(cfg.num_rows);
        early_oor = q_item.neg || (cfg.grid_step == 32'd0) || (cols_eff < 32'd2)
                    || (rows_eff < 32'd2);
        wr_ok     = (32'(q_item.row) < 32'(MAX_ROWS)) && (32'(q_item.col) < 32'(MAX_COLS));

        rem_shift = {rem_reg[31:0], dvd_reg[DIV_BITS-1]};
        qbit      = (rem_shift >= {1'b0, cfg.grid_step});
        rem_new   = qbit ? (rem_shift - {1'b0, cfg.grid_step}) : rem_shift;
        quo       = {dvd_reg[DIV_BITS-2:0], qbit};

        q_pop = (state_reg == S_IDLE) && q_valid;

        rd_col = cx_reg + CW'(k_reg[0]);
        rd_row = ry_reg + RW'(k_reg[1]);
        ram_we = q_pop && !q_item.lookup && wr_ok;
        if (ram_we) begin
            ram_addr = {RW'(q_item.row), CW'(q_item.col)};
        end else begin
            ram_addr = {rd_row, rd_col};
        end
        ram_wdata = VB'(q_item.value);

        if (k_reg < 3'd4) begin
            opnd = ram_rdata;
        end else if (k_reg == 3'd4) begin
            opnd = top_reg;
        end else begin
            opnd = bot_reg;
        end
        wsel = (k_reg < 3'd4) ? wx_reg : wy_reg;
        wgt  = k_reg[0] ? {1'b0, wsel} : (ONE_Q16 - {1'b0, wsel});
        sum  = acc_reg + SW'(prod_reg);
        half = sum[VB+15:16];
    end

    btt_ram #(
        .WIDTH(VB),
        .DEPTH(1 << AW)
    ) u_table (
        .aclk (aclk),
        .we   (ram_we),
        .addr (ram_addr),
        .wdata(ram_wdata),
        .rdata(ram_rdata)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
            cnt_reg     <= '0;
            k_reg       <= '0;
        end else begin
            if (m_valid_reg && m_ready && (state_reg != S_OUT)) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE: begin
                    if (q_pop && q_item.lookup) begin
                        ymag_reg <= q_item.ymag;
                        if (early_oor) begin
                            res_reg   <= '1;
                            oor_reg   <= 1'b1;
                            state_reg <= S_OUT;
                        end else begin
                            dvd_reg   <= {q_item.distance, 16'd0};
                            rem_reg   <= '0;
                            cnt_reg   <= '0;
                            state_reg <= S_DIVX;
                        end
                    end
                end
                S_DIVX: begin
                    dvd_reg <= quo;
                    rem_reg <= rem_new;
                    cnt_reg <= cnt_reg + 1'b1;
                    if (cnt_reg == CNTW'(DIV_BITS - 1)) begin
                        if (quo[47:16] >= cols_eff - 32'd1) begin
                            res_reg   <= '1;
                            oor_reg   <= 1'b1;
                            state_reg <= S_OUT;
                        end else begin
                            cx_reg    <= quo[16 +: CW];
                            wx_reg    <= quo[15:0];
                            dvd_reg   <= {ymag_reg, 16'd0};
                            rem_reg   <= '0;
                            cnt_reg   <= '0;
                            state_reg <= S_DIVY;
                        end
                    end
                end
                S_DIVY: begin
                    dvd_reg <= quo;
                    rem_reg <= rem_new;
                    cnt_reg <= cnt_reg + 1'b1;
                    if (cnt_reg == CNTW'(DIV_BITS - 1)) begin
                        if (quo[47:16] >= rows_eff - 32'd1) begin
                            res_reg   <= '1;
                            oor_reg   <= 1'b1;
                            state_reg <= S_OUT;
                        end else begin
                            ry_reg    <= quo[16 +: RW];
                            wy_reg    <= quo[15:0];
                            k_reg     <= '0;
                            acc_reg   <= '0;
                            state_reg <= S_RD;
                        end
                    end
                end
                S_RD: begin
                    state_reg <= S_MUL;
                end
                S_MUL: begin
                    prod_reg  <= PW'(opnd) * PW'(wgt);
                    state_reg <= S_ADD;
                end
                S_ADD: begin
                    k_reg <= k_reg + 3'd1;
                    if (k_reg[0]) begin
                        acc_reg <= '0;
                    end else begin
                        acc_reg <= sum;
                    end
                    if (k_reg == 3'd1) begin
                        top_reg <= half;
                    end
                    if (k_reg == 3'd3) begin
                        bot_reg <= half;
                    end
                    if (k_reg == 3'd5) begin
                        if ((VB > 32) && ((SW'(half) >> 32) != '0)) begin
                            res_reg <= '1;
                        end else begin
                            res_reg <= 32'(half);
                        end
                        oor_reg   <= 1'b0;
                        state_reg <= S_OUT;
                    end else if (k_reg < 3'd3) begin
                        state_reg <= S_RD;
                    end else begin
                        state_reg <= S_MUL;
                    end
                end
                S_OUT: begin
                    if (out_free) begin
                        m_valid_reg <= 1'b1;
                        tt_reg      <= res_reg;
                        m_oor_reg   <= oor_reg;
                        state_reg   <= S_IDLE;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_travel_time  = tt_reg;
    assign m_out_of_range = m_oor_reg;

    a_oor_ones: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_out_of_range) |-> (m_travel_time == 32'hFFFF_FFFF))
        else $error("out-of-range word without all-ones time");
    a_pop_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        q_pop |-> (state_reg == S_IDLE)) else $error("queue popped while busy");
    a_lookup_leaves: assert property (@(posedge aclk) disable iff (!aresetn)
        (q_pop && q_item.lookup) |=> (state_reg != S_IDLE))
        else $error("lookup dropped");
    a_k_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_RD) |-> (k_reg < 3'd4)) else $error("table read past fourth corner");
endmodule
`default_nettype wire
